FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the subscription router.
// Users include this file inside a module that has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, off while reset is asserted.
`define ISR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ISR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/isr_pkg.sv
// Package for the message ID subscription router: sizes, codes, payload
// structs and the hash step function. No dependencies.
`timescale 1ns / 1ps
package isr_pkg;

  localparam int TABLE_SLOTS      = 64;   // power of two, home slot is a mask
  localparam int SUBSCRIBER_SLOTS = 16;   // power of two

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int SUB_W   = (SUBSCRIBER_SLOTS > 1) ? $clog2(SUBSCRIBER_SLOTS) : 1;
  localparam int LINK_W  = SUB_W + 1;               // msb set means no link
  localparam int NU_W    = $clog2(SUBSCRIBER_SLOTS + 1);
  localparam int KEY_W   = 29;
  localparam int QUEUE_W = 8;

  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {SUB_W{1'b0}}};

  // Request types
  localparam logic [1:0] REQ_SUB   = 2'd0;
  localparam logic [1:0] REQ_UNSUB = 2'd1;
  localparam logic [1:0] REQ_COUNT = 2'd2;
  localparam logic [1:0] REQ_DISP  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TABLE_FULL = 3'd1;
  localparam logic [2:0] ST_POOL_FULL  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_NOT_SUB    = 3'd4;
  localparam logic [2:0] ST_NO_SUBS    = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [KEY_W-1:0]   can_id;
    logic [QUEUE_W-1:0] queue_id;
  } isr_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [QUEUE_W-1:0] target_queue;
    logic [4:0]         sub_count;
    logic               last;
  } isr_result_t;

  // Shift amount of each of the eight mix steps
  function automatic logic [4:0] mix_shamt(input logic [2:0] idx);
    logic [4:0] amt;
    case (idx)
      3'd0: amt = 5'd12;
      3'd1: amt = 5'd22;
      3'd2: amt = 5'd4;
      3'd3: amt = 5'd9;
      3'd4: amt = 5'd10;
      3'd5: amt = 5'd2;
      3'd6: amt = 5'd7;
      default: amt = 5'd12;
    endcase
    return amt;
  endfunction

  // One mix step: even steps add a left shift, odd steps xor a right shift
  function automatic logic [31:0] mix_step(input logic [31:0] h, input logic [2:0] idx);
    logic [31:0] t;
    t = idx[0] ? (h >> mix_shamt(idx)) : (h << mix_shamt(idx));
    return idx[0] ? (h ^ t) : (h + t);
  endfunction

endpackage

FILE: src/isr_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module isr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/id_subscription_router.sv
// Message ID subscription router. A request is taken only while the block is idle and
// is worked by a sequencer: the mix steps of a shared 32-bit shift-add-xor hash unit,
// the home slot, then a read state and a compare state per hash chain link (slot tables
// sit in RAMs with registered reads), a scan step per slot when a subscribe needs a new
// slot, a step to take a pool entry, a step per subscriber entry walked and a transfer
// per result, which the result side can stall.
// Dispatch gives one result per subscriber, the final one marked last; an ID with no
// subscribers gives a single ST_NO_SUBS result. Results sit in an output register, so a
// new request can be taken while the last result waits.
// Depends on isr_pkg, isr_ram and assert_macros.svh.
`timescale 1ns / 1ps
module id_subscription_router (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  isr_pkg::isr_req_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output isr_pkg::isr_result_t out_data_o
);
  import isr_pkg::*;
  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HASH   = 4'd1;
  localparam logic [3:0] S_HOME   = 4'd2;
  localparam logic [3:0] S_LKRD   = 4'd3;
  localparam logic [3:0] S_LKCMP  = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_ALLOC  = 4'd6;
  localparam logic [3:0] S_APPEND = 4'd7;
  localparam logic [3:0] S_UNSUB  = 4'd8;
  localparam logic [3:0] S_COUNT  = 4'd9;
  localparam logic [3:0] S_DISP   = 4'd10;
  localparam logic [3:0] S_RESP   = 4'd11;

  logic [3:0]              state_q;
  logic [2:0]              step_q;
  logic [31:0]             h_q;
  isr_req_t                req_q;
  logic [SLOT_W-1:0]       cur_q, tail_q, s_q, scan_q;
  logic                    hv_q;
  logic [SUB_W-1:0]        head_q, new_q;
  logic [LINK_W-1:0]       ent_q, prev_q, free_head_q;
  logic [NU_W-1:0]         cnt_q, never_used_q;
  logic [2:0]              status_q;
  logic [TABLE_SLOTS-1:0]  used_q, chain_vld_q, head_vld_q;
  logic [QUEUE_W-1:0]      entry_queue_q [SUBSCRIBER_SLOTS];
  logic [LINK_W-1:0]       entry_next_q  [SUBSCRIBER_SLOTS];
  logic                    out_valid_q;
  isr_result_t             out_q;

  // RAM ports
  logic                    key_we, chain_we, head_we;
  logic [SLOT_W-1:0]       key_waddr, chain_waddr, head_waddr;
  logic [SUB_W-1:0]        head_wdata;
  logic [KEY_W-1:0]        key_rdata;
  logic [SLOT_W-1:0]       chain_rdata;
  logic [SUB_W-1:0]        head_rdata;

  // Shared decode
  logic [SLOT_W-1:0]       home;
  logic [LINK_W-1:0]       nxt_ent;
  logic [QUEUE_W-1:0]      ent_queue;
  logic                    out_free, fh_valid, pool_ok, key_hit, is_sub;
  logic [SUB_W-1:0]        alloc_e;
  logic [NU_W-1:0]         cnt_inc;

  assign home      = h_q[SLOT_W-1:0];   // modulo of a power-of-two table
  assign nxt_ent   = entry_next_q[ent_q[SUB_W-1:0]];
  assign ent_queue = entry_queue_q[ent_q[SUB_W-1:0]];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fh_valid  = !free_head_q[LINK_W-1];
  assign pool_ok   = fh_valid || (never_used_q != NU_W'(SUBSCRIBER_SLOTS));
  assign alloc_e   = fh_valid ? free_head_q[SUB_W-1:0] : never_used_q[SUB_W-1:0];
  assign key_hit   = (key_rdata == req_q.can_id);
  assign is_sub    = (req_q.req_type == REQ_SUB);
  assign cnt_inc   = cnt_q + NU_W'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Slot table write strobes
  always_comb begin
    key_we      = 1'b0;
    key_waddr   = home;
    chain_we    = 1'b0;
    chain_waddr = tail_q;
    head_we     = 1'b0;
    head_waddr  = s_q;
    head_wdata  = alloc_e;
    case (state_q)
      S_HOME: begin
        key_we = !used_q[home] && is_sub;
      end
      S_SCAN: begin
        key_we    = !used_q[scan_q];
        key_waddr = scan_q;
        chain_we  = !used_q[scan_q];
      end
      S_ALLOC: begin
        head_we = pool_ok && !hv_q;
      end
      S_UNSUB: begin
        head_we    = (ent_queue == req_q.queue_id) && prev_q[LINK_W-1];
        head_wdata = nxt_ent[SUB_W-1:0];
      end
      default: begin
      end
    endcase
  end

  isr_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(req_q.can_id),
    .raddr_i(cur_q), .rdata_o(key_rdata)
  );

  isr_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_chain_ram (
    .clk_i, .we_i(chain_we), .waddr_i(chain_waddr), .wdata_i(scan_q),
    .raddr_i(cur_q), .rdata_o(chain_rdata)
  );

  isr_ram #(.WIDTH(SUB_W), .DEPTH(TABLE_SLOTS)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(cur_q), .rdata_o(head_rdata)
  );

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      chain_vld_q  <= '0;
      head_vld_q   <= '0;
      free_head_q  <= LINK_NONE;
      never_used_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            h_q     <= {3'b000, in_data_i.can_id};
            step_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          h_q    <= mix_step(h_q, step_q);
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            state_q <= S_HOME;
          end
        end
        S_HOME: begin
          cur_q <= home;
          if (used_q[home]) begin
            state_q <= S_LKRD;
          end else if (is_sub) begin
            used_q[home] <= 1'b1;
            s_q          <= home;
            hv_q         <= 1'b0;
            state_q      <= S_ALLOC;
          end else begin
            status_q <= ST_UNKNOWN;
            state_q  <= S_RESP;
          end
        end
        S_LKRD: begin
          state_q <= S_LKCMP;
        end
        S_LKCMP: begin
          if (key_hit) begin
            s_q    <= cur_q;
            head_q <= head_rdata;
            hv_q   <= head_vld_q[cur_q];
            ent_q  <= {!head_vld_q[cur_q], head_rdata};
            prev_q <= LINK_NONE;
            case (req_q.req_type)
              REQ_SUB: state_q <= S_ALLOC;
              REQ_UNSUB: begin
                status_q <= ST_NOT_SUB;
                state_q  <= head_vld_q[cur_q] ? S_UNSUB : S_RESP;
              end
              REQ_COUNT: begin
                status_q <= ST_OK;
                state_q  <= head_vld_q[cur_q] ? S_COUNT : S_RESP;
              end
              default: begin
                status_q <= ST_NO_SUBS;
                state_q  <= head_vld_q[cur_q] ? S_DISP : S_RESP;
              end
            endcase
          end else if (chain_vld_q[cur_q]) begin
            cur_q   <= chain_rdata;
            state_q <= S_LKRD;
          end else begin
            tail_q <= cur_q;
            scan_q <= '0;
            if (is_sub) begin
              state_q <= S_SCAN;
            end else begin
              status_q <= ST_UNKNOWN;
              state_q  <= S_RESP;
            end
          end
        end
        // Linear scan for a free slot, linked to the chain tail
        S_SCAN: begin
          if (!used_q[scan_q]) begin
            used_q[scan_q]      <= 1'b1;
            chain_vld_q[tail_q] <= 1'b1;
            s_q                 <= scan_q;
            hv_q                <= 1'b0;
            state_q             <= S_ALLOC;
          end else if (scan_q == SLOT_W'(TABLE_SLOTS - 1)) begin
            status_q <= ST_TABLE_FULL;
            state_q  <= S_RESP;
          end else begin
            scan_q <= scan_q + SLOT_W'(1);
          end
        end
        // Take an entry from the free list, else from the bump counter
        S_ALLOC: begin
          if (pool_ok) begin
            new_q <= alloc_e;
            if (fh_valid) begin
              free_head_q <= entry_next_q[alloc_e];
            end else begin
              never_used_q <= never_used_q + NU_W'(1);
            end
            if (!hv_q) begin
              head_vld_q[s_q] <= 1'b1;
              status_q        <= ST_OK;
              state_q         <= S_RESP;
            end else begin
              ent_q   <= {1'b0, head_q};
              state_q <= S_APPEND;
            end
          end else begin
            status_q <= ST_POOL_FULL;
            state_q  <= S_RESP;
          end
        end
        S_APPEND: begin
          if (nxt_ent[LINK_W-1]) begin
            status_q <= ST_OK;
            state_q  <= S_RESP;
          end else begin
            ent_q <= nxt_ent;
          end
        end
        S_UNSUB: begin
          if (ent_queue == req_q.queue_id) begin
            if (prev_q[LINK_W-1]) begin
              head_vld_q[s_q] <= !nxt_ent[LINK_W-1];
            end
            free_head_q <= ent_q;
            status_q    <= ST_OK;
            state_q     <= S_RESP;
          end else begin
            prev_q <= ent_q;
            if (nxt_ent[LINK_W-1]) begin
              state_q <= S_RESP;
            end else begin
              ent_q <= nxt_ent;
            end
          end
        end
        S_COUNT: begin
          cnt_q <= cnt_inc;
          if (nxt_ent[LINK_W-1] || cnt_inc == NU_W'(SUBSCRIBER_SLOTS)) begin
            state_q <= S_RESP;
          end else begin
            ent_q <= nxt_ent;
          end
        end
        // One transfer per subscriber, in list order
        S_DISP: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.status       <= ST_OK;
            out_q.target_queue <= ent_queue;
            out_q.sub_count    <= '0;
            out_q.last         <= nxt_ent[LINK_W-1] || cnt_inc == NU_W'(SUBSCRIBER_SLOTS);
            if (nxt_ent[LINK_W-1] || cnt_inc == NU_W'(SUBSCRIBER_SLOTS)) begin
              state_q <= S_IDLE;
            end else begin
              ent_q <= nxt_ent;
              cnt_q <= cnt_inc;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.status       <= status_q;
            out_q.target_queue <= '0;
            out_q.sub_count    <= 5'(cnt_q);
            out_q.last         <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Subscriber entry pool, written on allocation, append and removal
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_ALLOC: begin
        if (pool_ok) begin
          entry_queue_q[alloc_e] <= req_q.queue_id;
          entry_next_q[alloc_e]  <= LINK_NONE;
        end
      end
      S_APPEND: begin
        if (nxt_ent[LINK_W-1]) begin
          entry_next_q[ent_q[SUB_W-1:0]] <= {1'b0, new_q};
        end
      end
      S_UNSUB: begin
        if (ent_queue == req_q.queue_id) begin
          if (!prev_q[LINK_W-1]) begin
            entry_next_q[prev_q[SUB_W-1:0]] <= nxt_ent;
          end
          entry_next_q[ent_q[SUB_W-1:0]] <= free_head_q;
        end
      end
      default: begin
      end
    endcase
  end

  `ISR_ASSERT_ALWAYS(a_pool_bound, never_used_q <= NU_W'(SUBSCRIBER_SLOTS), "pool overrun")
  `ISR_ASSERT(a_free_head_issued, fh_valid |-> NU_W'(alloc_e) < never_used_q, "bad free head")
  `ISR_ASSERT(a_chain_on_used, (chain_vld_q & ~used_q) == '0, "chain link on an empty slot")
  `ISR_ASSERT(a_head_on_used, (head_vld_q & ~used_q) == '0, "list on an empty slot")
  `ISR_ASSERT(a_accept_starts_hash, in_valid_i && !in_stall_o |=> state_q == S_HASH, "no hash")

endmodule
